// ===== design/fwm_pkg.sv =====
`default_nettype none
package fwm_pkg;

	// Window selector codes, as written to the window_type register
	typedef enum logic [1:0] {
		WIN_HANN,
		WIN_HAMMING,
		WIN_BARTLETT,
		WIN_BLACKMAN_HARRIS
	} win_t;

	// Index of a cosine term within a window sum (0 is the constant term)
	localparam int TERM_W = 2;
	typedef logic [TERM_W-1:0] term_t;
	localparam term_t TERM_CONST  = 2'd0;
	localparam term_t TERM_FIRST  = 2'd1;
	localparam term_t TERM_SECOND = 2'd2;
	localparam term_t TERM_LAST   = 2'd3;

	// Window weights in units of 1e-5, entry {window code, term}
	localparam logic [0:15][16:0] WEIGHT_E5 = {
		17'd50000, 17'd50000, 17'd0,     17'd0,
		17'd54000, 17'd46000, 17'd0,     17'd0,
		17'd0,     17'd0,     17'd0,     17'd0,
		17'd35875, 17'd48829, 17'd14128, 17'd1168
	};

	// pi/2 in Q30
	localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

	// Controller to datapath commands
	typedef struct packed {
		logic  fill;
		logic  load;
		logic  rd;
		logic  mul;
		logic  acc;
		logic  win;
		logic  prod;
		logic  out_load;
		term_t term;
	} fwm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_done;
		logic bartlett;
	} fwm_status_t;

	// Unsigned long division by shift and subtract; evaluated at elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Weight rounded to Q1.frac, evaluated at elaboration
	function automatic logic [63:0] weight_q(logic [63:0] e5, int unsigned frac);
		return udiv64((e5 << frac) + 64'd50000, 64'd100000);
	endfunction

	// cos(pi/2 * r / 2^(max_log2-2)) rounded to Q1.frac, by an integer Taylor
	// series in Q30; evaluated at elaboration only
	function automatic logic [63:0] quarter_cos(int unsigned r, int unsigned max_log2,
			int unsigned frac);
		logic [63:0] qtr;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] den;
		longint      sum;
		longint      v;
		qtr  = 64'd1 << (max_log2 - 2);
		x    = (HALFPI_Q30 * 64'(r) + (qtr >> 1)) >> (max_log2 - 2);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = longint'(term);
		for (int n = 0; n < 20; n++) begin
			den  = 64'((2 * n + 1) * (2 * n + 2));
			term = (term * x2) >> 30;
			term = udiv64(term, den);
			if ((n & 1) == 1) begin
				sum = sum + longint'(term);
			end else begin
				sum = sum - longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + (longint'(1) << (30 - frac - 1))) >>> (30 - frac);
		if (v > (longint'(1) << frac)) begin
			v = longint'(1) << frac;
		end
		return 64'(v);
	endfunction

endpackage
`default_nettype wire

// ===== design/fwm_ram.sv =====
`default_nettype none
module fwm_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/fwm_ctrl.sv =====
`default_nettype none
module fwm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  fwm_pkg::fwm_status_t status,
	output fwm_pkg::fwm_cmd_t    cmd
);
	import fwm_pkg::*;

	typedef enum logic [2:0] {
		S_FILL,
		S_IDLE,
		S_RD,
		S_MUL,
		S_ACC,
		S_WIN,
		S_PROD,
		S_OUT
	} state_t;

	state_t state_q;
	term_t  term_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_FILL;
			term_q     <= TERM_FIRST;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_FILL: begin
					if (status.fill_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						term_q  <= TERM_FIRST;
						state_q <= status.bartlett ? S_WIN : S_RD;
					end
				end
				S_RD:   state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					if (term_q == TERM_LAST) begin
						state_q <= S_WIN;
					end else begin
						term_q  <= term_q + TERM_FIRST;
						state_q <= S_RD;
					end
				end
				S_WIN:  state_q <= S_PROD;
				S_PROD: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// Raise valid as a result is stored, drop it once it is taken
			if ((state_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.fill     = (state_q == S_FILL);
		cmd.load     = (state_q == S_IDLE) && s_tvalid;
		cmd.rd       = (state_q == S_RD);
		cmd.mul      = (state_q == S_MUL);
		cmd.acc      = (state_q == S_ACC);
		cmd.win      = (state_q == S_WIN);
		cmd.prod     = (state_q == S_PROD);
		cmd.out_load = (state_q == S_OUT) && out_free;
		cmd.term     = term_q;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

// ===== design/fwm_dp.sv =====
`default_nettype none
module fwm_dp #(
	parameter int MAX_LOG2_LENGTH = 12,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int COEF_WIDTH      = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fwm_pkg::fwm_cmd_t        cmd,
	output fwm_pkg::fwm_status_t     status,
	input  fwm_pkg::win_t            window_type,
	input  logic [3:0]               log2_length,
	input  logic [SAMPLE_WIDTH-1:0]  sample,
	output logic [SAMPLE_WIDTH-1:0]  windowed_sample,
	output logic                     block_end
);
	import fwm_pkg::*;

	localparam int M         = MAX_LOG2_LENGTH;
	localparam int SW        = SAMPLE_WIDTH;
	localparam int CW        = COEF_WIDTH;
	localparam int F         = CW - 1;
	localparam int QTR       = 1 << (M - 2);
	localparam int ROM_DEPTH = QTR + 1;
	localparam int RA_W      = $clog2(ROM_DEPTH);
	localparam int ACC_W     = 2 * CW + 2;
	localparam int BW        = M + CW + 1;
	localparam int PW        = SW + CW + 1;
	localparam int LEN_W     = 5;
	localparam int ONE       = 1 << F;
	localparam int HALF_LSB  = 1 << (F - 1);

	localparam logic [LEN_W-1:0] MIN_L    = LEN_W'(2);
	localparam logic [LEN_W-1:0] MAX_L    = LEN_W'(M);
	localparam logic [RA_W-1:0]  QTR_ADDR = RA_W'(QTR);
	localparam logic [M-1:0]     RMASK    = M'(QTR - 1);
	localparam logic [M-1:0]     HALF     = M'(1 << (M - 1));

	typedef logic [ROM_DEPTH-1:0][CW-1:0] cos_tab_t;
	typedef logic [15:0][CW-1:0]          wtab_t;

	function automatic cos_tab_t build_cos();
		cos_tab_t t;
		for (int r = 0; r < ROM_DEPTH; r++) begin
			if (r == 0) begin
				t[r] = CW'(ONE);
			end else if (r == QTR) begin
				t[r] = '0;
			end else begin
				t[r] = CW'(quarter_cos(r, M, F));
			end
		end
		return t;
	endfunction

	function automatic wtab_t build_weights();
		wtab_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = CW'(weight_q(64'(WEIGHT_E5[i]), F));
		end
		return t;
	endfunction

	localparam cos_tab_t COS_TABLE = build_cos();
	localparam wtab_t    WEIGHTS   = build_weights();

	// Quarter-wave cosine table load after reset
	logic [RA_W-1:0] fill_cnt_q;
	logic            fill_last;

	assign fill_last = (fill_cnt_q == QTR_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (cmd.fill && !fill_last) begin
			fill_cnt_q <= fill_cnt_q + RA_W'(1);
		end
	end

	// Index and phase of the incoming sample
	logic [M-1:0]     sample_index_q;
	logic [LEN_W-1:0] eff_l;
	logic [M:0]       span;
	logic [M-1:0]     nmask;
	logic [M-1:0]     idx;
	logic [M-1:0]     phase;

	always_comb begin
		if ({1'b0, log2_length} < MIN_L) begin
			eff_l = MIN_L;
		end else if ({1'b0, log2_length} > MAX_L) begin
			eff_l = MAX_L;
		end else begin
			eff_l = {1'b0, log2_length};
		end
		span  = (M+1)'(1) << eff_l;
		nmask = M'(span - (M+1)'(1));
		idx   = sample_index_q & nmask;
		phase = idx << (MAX_L - eff_l);
	end

	logic signed [SW-1:0] sample_q;
	logic [M-1:0]         phase_q;
	logic                 last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
		end else if (cmd.load) begin
			sample_index_q <= M'(idx + M'(1)) & nmask;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= $signed(sample);
			phase_q  <= phase;
			last_q   <= (idx == nmask);
		end
	end

	// Cosine address for the current term: fold the multiple of the phase
	// onto the quarter wave
	logic [M-1:0]    mult;
	logic [M-1:0]    rfull;
	logic [RA_W-1:0] rq;
	logic [1:0]      quad;
	logic [RA_W-1:0] raddr;
	logic            cos_neg;
	logic [CW-1:0]   cos_val;

	always_comb begin
		case (cmd.term)
			TERM_FIRST:  mult = phase_q;
			TERM_SECOND: mult = phase_q << 1;
			default:     mult = phase_q + (phase_q << 1);
		endcase
		rfull   = mult & RMASK;
		rq      = rfull[RA_W-1:0];
		quad    = mult[M-1 -: 2];
		raddr   = (quad == 2'd0 || quad == 2'd2) ? rq : QTR_ADDR - rq;
		cos_neg = (quad == 2'd1 || quad == 2'd2);
	end

	fwm_ram #(
		.WIDTH(CW),
		.DEPTH(ROM_DEPTH)
	) u_cos_rom (
		.clk  (clk),
		.we   (cmd.fill),
		.waddr(fill_cnt_q),
		.wdata(COS_TABLE[fill_cnt_q]),
		.raddr(raddr),
		.rdata(cos_val)
	);

	// Term multiply and accumulate
	logic                    cos_neg_q;
	logic                    sub_q;
	logic [2*CW-1:0]         term_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term_ext;

	assign term_ext = $signed(ACC_W'(term_q));

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			cos_neg_q <= cos_neg;
		end
		if (cmd.mul) begin
			term_q <= WEIGHTS[{window_type, cmd.term}] * cos_val;
			// odd terms enter with a minus sign
			sub_q  <= cos_neg_q ^ cmd.term[0];
		end
		if (cmd.load) begin
			acc_q <= $signed(ACC_W'(WEIGHTS[{window_type, TERM_CONST}]) << F);
		end else if (cmd.acc) begin
			acc_q <= sub_q ? acc_q - term_ext : acc_q + term_ext;
		end
	end

	// Coefficient: round the cosine sum, or build the triangle
	logic [ACC_W-1:0] acc_round;
	logic [CW-1:0]    w_cos;
	logic [M:0]       u;
	logic [BW-1:0]    bart;
	logic [CW-1:0]    w_bart;
	logic [CW-1:0]    w_q;

	always_comb begin
		acc_round = acc_q[ACC_W-1] ? '0 : ($unsigned(acc_q) + ACC_W'(HALF_LSB)) >> F;
		w_cos     = (acc_round > ACC_W'(ONE)) ? CW'(ONE) : acc_round[CW-1:0];
		u         = (phase_q > HALF) ? ((M+1)'(1) << M) - {1'b0, phase_q}
		                             : {1'b0, phase_q};
		bart      = ((BW'(u) << CW) + BW'(HALF)) >> M;
		w_bart    = (bart > BW'(ONE)) ? CW'(ONE) : bart[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.win) begin
			w_q <= (window_type == WIN_BARTLETT) ? w_bart : w_cos;
		end
	end

	// Sample product, round half up, saturate
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] rnd;
	logic signed [PW-1:0] shifted;
	logic [SW-1:0]        sat;
	logic [SW-1:0]        windowed_sample_q;
	logic                 block_end_q;

	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			prod_q <= sample_q * $signed({1'b0, w_q});
		end
	end

	always_comb begin
		rnd     = prod_q + $signed(PW'(HALF_LSB));
		shifted = rnd >>> F;
		if (&shifted[PW-1:SW-1] || ~|shifted[PW-1:SW-1]) begin
			sat = shifted[SW-1:0];
		end else if (shifted[PW-1]) begin
			sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			windowed_sample_q <= sat;
			block_end_q       <= last_q;
		end
	end

	assign windowed_sample  = windowed_sample_q;
	assign block_end        = block_end_q;
	assign status.fill_done = fill_last;
	assign status.bartlett  = (window_type == WIN_BARTLETT);

endmodule
`default_nettype wire

// ===== design/fft_window_multiplier_top.sv =====
`default_nettype none
// Window multiplier for an FFT front end. Each sample on the slave stream is
// multiplied by a periodic window coefficient w(i), i being its position in a
// block of N = 2^log2_length samples (log2_length clamped to 2..MAX_LOG2_LENGTH),
// rounded half up and saturated to SAMPLE_WIDTH bits; the result leaves on the
// master stream with tlast marking index N-1. Windows: Hann, Hamming, Bartlett
// and 4-term Blackman-Harris, selected by window_type. Cosines come from a
// quarter-wave table in a RAM of 2^(MAX_LOG2_LENGTH-2)+1 entries, which is
// loaded after reset: tready stays low until the load is done, while register
// writes are taken as ever. One transaction is processed at a time. From the
// acceptance of a Hann, Hamming or Blackman-Harris sample to the next tready,
// the three cosine terms each take a table read, a multiply and an accumulate
// through the single RAM read port and one shared multiplier, then the
// coefficient is rounded, multiplied by the sample and rounded again. A
// Bartlett sample skips the cosine terms. A result waiting in the output
// register does not hold off the next transaction; only a full output register
// stalls the final step. Registers: window_type at byte address 0 and
// log2_length at byte address 4; write them only while the block is idle.
module fft_window_multiplier_top #(
	parameter int MAX_LOG2_LENGTH = 12,
	parameter int SAMPLE_WIDTH    = 16,
	parameter int COEF_WIDTH      = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Slave stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample
	// Master stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // windowed_sample
	output logic                                  m_tlast,   // block_end
	// Register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import fwm_pkg::*;

	localparam int TD_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// Register select is address bit 2
	localparam logic REG_WINDOW_TYPE = 1'b0;
	localparam logic REG_LOG2_LENGTH = 1'b1;
	localparam logic [3:0] LOG2_LENGTH_RESET = 4'd10;

	win_t       window_type_q;
	logic [3:0] log2_length_q;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Hold configuration; a write lands on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_type_q <= WIN_HANN;
			log2_length_q <= LOG2_LENGTH_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_WINDOW_TYPE: window_type_q <= win_t'(pwdata[1:0]);
				REG_LOG2_LENGTH: log2_length_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW_TYPE: prdata = {30'd0, window_type_q};
			REG_LOG2_LENGTH: prdata = {28'd0, log2_length_q};
			default:         prdata = '0;
		endcase
	end

	fwm_cmd_t              cmd;
	fwm_status_t           status;
	logic [SAMPLE_WIDTH-1:0] windowed_sample;

	// Sequence each transaction through the datapath
	fwm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// Index counter, cosine table, coefficient and product arithmetic
	fwm_dp #(
		.MAX_LOG2_LENGTH(MAX_LOG2_LENGTH),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_WIDTH     (COEF_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.window_type    (window_type_q),
		.log2_length    (log2_length_q),
		.sample         (s_tdata[SAMPLE_WIDTH-1:0]),
		.windowed_sample(windowed_sample),
		.block_end      (m_tlast)
	);

	// Zero-pad the result up to whole bytes
	assign m_tdata = TD_W'(windowed_sample);

	// At most one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill, cmd.load, cmd.rd, cmd.mul, cmd.acc, cmd.win, cmd.prod,
			cmd.out_load}))
		else $error("more than one datapath step in a cycle");

	// Drop tready once a transaction is taken, until its result is stored
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !s_tready)
		else $error("new transaction accepted while one is in flight");

	// No transaction while the cosine table is still loading
	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |-> !s_tready)
		else $error("transaction accepted during table load");

	// A stored result shows up as valid in the next cycle
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("result stored without valid");

endmodule
`default_nettype wire

// ===== dv/fft_window_multiplier_top_tb.sv =====
`timescale 1ns / 1ps
module fft_window_multiplier_top_tb;
	import fwm_pkg::*;

	// Block geometry at the default parameters
	localparam int MAX_L       = 12;
	localparam int FRAC        = 17;
	localparam longint ONE     = longint'(1) << FRAC;
	localparam int QTR         = 1 << (MAX_L - 2);
	localparam int CIRCLE_MASK = (1 << MAX_L) - 1;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Register map
	localparam logic [2:0] ADDR_WINDOW_TYPE = 3'd0;
	localparam logic [2:0] ADDR_LOG2_LENGTH = 3'd4;

	// Idle odds in percent, and the quiet time after the last result
	localparam int GAP_PCT      = 32;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} windowed_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // windowed_sample
	logic        m_tlast;        // block_end
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: register copies and the position within the block
	win_t        cfg_win   = WIN_HANN;
	logic [3:0]  cfg_log2  = 4'd10;
	int unsigned blk_index = 0;
	int          cos_table [0:QTR];

	windowed_t   pending_results [$];
	int          items_sent = 0;
	int          errors     = 0;
	bit          tx_gaps    = 1'b1;
	bit          rx_gaps    = 1'b1;

	fft_window_multiplier_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Window arithmetic
	// ------------------------------------------------------------------

	// Quarter-wave cosine entry r in Q1.17, Taylor series carried in Q30
	function automatic int quarter_wave_cos(int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          v;
		x    = (HALF_PI_Q30 * longint'(r) + (QTR >> 1)) >> (MAX_L - 2);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = longint'(term);
		for (int n = 0; n < 20; n++) begin
			term = (term * x2) >> 30;
			term = term / longint'((2 * n + 1) * (2 * n + 2));
			if (n % 2 == 1) begin
				sum = sum + longint'(term);
			end else begin
				sum = sum - longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + (longint'(1) << (30 - FRAC - 1))) >>> (30 - FRAC);
		if (v > ONE) begin
			v = ONE;
		end
		return int'(v);
	endfunction

	// Full-circle cosine by quadrant symmetry
	function automatic longint cosine_at(int unsigned p);
		int unsigned q;
		int unsigned r;
		p = p & CIRCLE_MASK;
		q = p >> (MAX_L - 2);
		r = p & (QTR - 1);
		case (q)
			0:       return cos_table[r];
			1:       return -longint'(cos_table[QTR - r]);
			2:       return -longint'(cos_table[r]);
			default: return cos_table[QTR - r];
		endcase
	endfunction

	// Term k weight of a cosine-sum window, rounded to Q1.17
	function automatic longint taper_weight(win_t win, int k);
		longint unsigned e5;
		case (win)
			WIN_HANN:    e5 = (k < 2) ? 64'd50000 : 64'd0;
			WIN_HAMMING: e5 = (k == 0) ? 64'd54000 : (k == 1) ? 64'd46000 : 64'd0;
			WIN_BLACKMAN_HARRIS: begin
				e5 = (k == 0) ? 64'd35875 : (k == 1) ? 64'd48829 :
					(k == 2) ? 64'd14128 : 64'd1168;
			end
			default:     e5 = 64'd0;
		endcase
		return longint'(((e5 << FRAC) + 64'd50000) / 64'd100000);
	endfunction

	function automatic longint window_coef(win_t win, int unsigned phase);
		longint          w;
		longint          acc;
		longint unsigned u;
		if (win == WIN_BARTLETT) begin
			// Fold the triangle about the half circle
			u = phase;
			if (u > (64'd1 << (MAX_L - 1))) begin
				u = (64'd1 << MAX_L) - u;
			end
			w = longint'(((u << (FRAC + 1)) + (64'd1 << (MAX_L - 1))) >> MAX_L);
		end else begin
			acc = taper_weight(win, 0) * ONE
				- taper_weight(win, 1) * cosine_at(phase)
				+ taper_weight(win, 2) * cosine_at(2 * phase)
				- taper_weight(win, 3) * cosine_at(3 * phase);
			if (acc < 0) begin
				acc = 0;
			end
			w = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
		end
		if (w > ONE) begin
			w = ONE;
		end
		if (w < 0) begin
			w = 0;
		end
		return w;
	endfunction

	// Expected result for one accepted sample; advances the block position
	function automatic windowed_t window_and_advance(logic signed [15:0] smp);
		int unsigned len;
		int unsigned nmask;
		int unsigned idx;
		int unsigned phase;
		longint      prod;
		windowed_t   res_item;
		len = cfg_log2;
		if (len < 2) begin
			len = 2;
		end
		if (len > MAX_L) begin
			len = MAX_L;
		end
		nmask = (1 << len) - 1;
		idx   = blk_index & nmask;
		phase = (idx << (MAX_L - len)) & CIRCLE_MASK;
		prod  = longint'(smp) * window_coef(cfg_win, phase) + (longint'(1) << (FRAC - 1));
		prod  = prod >>> FRAC;
		if (prod > 32767) begin
			prod = 32767;
		end
		if (prod < -32768) begin
			prod = -32768;
		end
		res_item.value = prod[15:0];
		res_item.last  = (idx == nmask);
		blk_index      = (idx + 1) & nmask;
		return res_item;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers: every task starts and ends at a falling edge
	// ------------------------------------------------------------------

	function automatic logic [15:0] edge_sample(int k);
		case (k)
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	// Mostly full-range noise, with the field extremes mixed in
	function automatic logic [15:0] random_sample();
		if ($urandom_range(99) < 20) begin
			return edge_sample($urandom_range(4));
		end
		return 16'($urandom);
	endfunction

	// Offer one sample and hold it until the transaction completes. Leave
	// tvalid high on exit so back-to-back samples never drop it.
	task automatic send_sample(logic [15:0] smp);
		while (tx_gaps && $urandom_range(99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_results.push_back(window_and_advance(smp));
		items_sent++;
		@(negedge clk);
	endtask

	// Drop tvalid, wait for every outstanding result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Two-phase register write; junk above the field width must be ignored
	task automatic write_reg(logic [2:0] addr, logic [3:0] value);
		logic [31:0] keep;
		keep    = (addr == ADDR_WINDOW_TYPE) ? 32'h3 : 32'hF;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= (32'($urandom) & ~keep) | (32'(value) & keep);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (addr == ADDR_WINDOW_TYPE) begin
			cfg_win = win_t'(value[1:0]);
		end else if (addr == ADDR_LOG2_LENGTH) begin
			cfg_log2 = value;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(win_t win, logic [3:0] log2_len);
		settle();
		write_reg(ADDR_WINDOW_TYPE, 4'(win));
		write_reg(ADDR_LOG2_LENGTH, log2_len);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Run a few samples on the reset settings, which includes the table fill
	task automatic test_reset_config();
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h3039);
	endtask

	// Shortest block with every window. The position carried over from the
	// longer block lands the first sample on the block's last index, and the
	// coefficient reaches 1.0 mid-block.
	task automatic test_window_extremes();
		win_t win;
		for (int k = 0; k < 4; k++) begin
			win = win_t'(k);
			configure(win, 4'd2);
			for (int j = 0; j < 4; j++) begin
				send_sample(edge_sample((k + j) % 5));
			end
		end
	endtask

	// Length codes outside 2..12 clamp; the position is never cleared
	task automatic test_length_clamp();
		configure(WIN_HAMMING, 4'd15);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		configure(WIN_BLACKMAN_HARRIS, 4'd0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		configure(WIN_BARTLETT, 4'd13);
		send_sample(16'h7FFF);
		configure(WIN_HANN, 4'd1);
		send_sample(16'hFFFF);
	endtask

	// Long stretch with neither side idling
	task automatic test_full_rate(int count);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		configure(WIN_BLACKMAN_HARRIS, 4'd3);
		for (int j = 0; j < count; j++) begin
			send_sample(random_sample());
		end
		settle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Random settings per phase; short blocks dominate so block ends are frequent
	task automatic test_random_blocks(int count);
		int          stop_at;
		int          pick;
		int          burst;
		logic [3:0]  log2_len;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				log2_len = 4'($urandom_range(5, 2));
			end else if (pick < 80) begin
				log2_len = 4'($urandom_range(9, 6));
			end else if (pick < 90) begin
				log2_len = 4'($urandom_range(12, 10));
			end else if (pick < 95) begin
				log2_len = 4'($urandom_range(1, 0));
			end else begin
				log2_len = 4'($urandom_range(15, 13));
			end
			burst = (log2_len >= 4'd10) ? $urandom_range(80, 20) : $urandom_range(100, 8);
			configure(win_t'($urandom_range(3)), log2_len);
			for (int j = 0; j < burst; j++) begin
				send_sample(random_sample());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Stall the result stream at random except during the full-rate test
	always @(negedge clk) begin
		m_tready <= !rx_gaps || ($urandom_range(99) >= GAP_PCT);
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		windowed_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result tdata %0d tlast %0b",
					$time, $signed(m_tdata), m_tlast);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value) begin
					$display("%0t: windowed_sample expected %0d actual %0d",
						$time, $signed(want.value), $signed(m_tdata));
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: block_end expected %0b actual %0b",
						$time, want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		for (int r = 0; r < QTR; r++) begin
			cos_table[r] = quarter_wave_cos(r);
		end
		cos_table[0]   = int'(ONE);
		cos_table[QTR] = 0;

		// Hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_config();
		test_window_extremes();
		test_length_clamp();
		test_full_rate(200);
		test_random_blocks(1400);
		settle();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, table fill included
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

endmodule
